>>> src/idqr_pkg.sv
`timescale 1ns / 1ps

package idqr_pkg;

  localparam int unsigned FIELD_W  = 64;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned MIN_DATA_W = 8;

  typedef logic [FIELD_W-1:0] field_t;

  typedef enum logic [1:0] {
    CMD_UQUO = 2'd0,
    CMD_UREM = 2'd1,
    CMD_SQUO = 2'd2,
    CMD_SREM = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0] command;
    field_t     dividend;
    field_t     divisor;
  } req_t;

  typedef struct packed {
    field_t result;
    logic   div_by_zero;
  } rsp_t;

  // Per-request control that travels alongside the datapath.
  typedef struct packed {
    logic sel_rem;
    logic neg_res;
    logic dbz;
  } meta_t;

endpackage

>>> src/idqr_prep.sv
`timescale 1ns / 1ps

module idqr_prep #(
  parameter int unsigned DATA_WIDTH = idqr_pkg::DATA_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  idqr_pkg::req_t        req_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [DATA_WIDTH-1:0] r_o,
  output logic [DATA_WIDTH-1:0] nq_o,
  output logic [DATA_WIDTH-1:0] den_o,
  output idqr_pkg::meta_t       meta_o
);

  logic                  valid_q;
  logic [DATA_WIDTH-1:0] nq_d, nq_q;
  logic [DATA_WIDTH-1:0] den_d, den_q;
  idqr_pkg::meta_t       meta_d, meta_q;

  logic [DATA_WIDTH-1:0] a, b;
  logic                  sgn_op, na, nb, sel_rem;

  always_comb begin
    a         = req_i.dividend[DATA_WIDTH-1:0];
    b         = req_i.divisor[DATA_WIDTH-1:0];
    sgn_op    = (req_i.command == idqr_pkg::CMD_SQUO) ||
                (req_i.command == idqr_pkg::CMD_SREM);
    sel_rem   = (req_i.command == idqr_pkg::CMD_UREM) ||
                (req_i.command == idqr_pkg::CMD_SREM);
    na        = sgn_op & a[DATA_WIDTH-1];
    nb        = sgn_op & b[DATA_WIDTH-1];
    // divide magnitudes; the sign is restored at the end
    nq_d      = na ? (~a + 1'b1) : a;
    den_d     = nb ? (~b + 1'b1) : b;
    meta_d.sel_rem = sel_rem;
    meta_d.neg_res = sel_rem ? na : (na ^ nb);
    meta_d.dbz     = (b == '0);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      nq_q   <= nq_d;
      den_q  <= den_d;
      meta_q <= meta_d;
    end
  end

  assign valid_o = valid_q;
  assign r_o     = '0;
  assign nq_o    = nq_q;
  assign den_o   = den_q;
  assign meta_o  = meta_q;

endmodule

>>> src/idqr_step.sv
`timescale 1ns / 1ps

module idqr_step #(
  parameter int unsigned DATA_WIDTH = idqr_pkg::DATA_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [DATA_WIDTH-1:0] r_i,
  input  logic [DATA_WIDTH-1:0] nq_i,
  input  logic [DATA_WIDTH-1:0] den_i,
  input  idqr_pkg::meta_t       meta_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [DATA_WIDTH-1:0] r_o,
  output logic [DATA_WIDTH-1:0] nq_o,
  output logic [DATA_WIDTH-1:0] den_o,
  output idqr_pkg::meta_t       meta_o
);

  logic                  valid_q;
  logic [DATA_WIDTH-1:0] r_d, r_q;
  logic [DATA_WIDTH-1:0] nq_d, nq_q;
  logic [DATA_WIDTH-1:0] den_q;
  idqr_pkg::meta_t       meta_q;

  logic [DATA_WIDTH:0]   rsh, diff;
  logic                  take;

  // The bit shifted out of the partial remainder sits in rsh's top bit, so a
  // borrow-free subtract covers both the carry and the compare.
  always_comb begin
    rsh  = {r_i, nq_i[DATA_WIDTH-1]};
    diff = rsh - {1'b0, den_i};
    take = !diff[DATA_WIDTH];
    r_d  = take ? diff[DATA_WIDTH-1:0] : rsh[DATA_WIDTH-1:0];
    nq_d = {nq_i[DATA_WIDTH-2:0], take};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      r_q    <= r_d;
      nq_q   <= nq_d;
      den_q  <= den_i;
      meta_q <= meta_i;
    end
  end

  assign valid_o = valid_q;
  assign r_o     = r_q;
  assign nq_o    = nq_q;
  assign den_o   = den_q;
  assign meta_o  = meta_q;

endmodule

>>> src/idqr_post.sv
`timescale 1ns / 1ps

module idqr_post #(
  parameter int unsigned DATA_WIDTH = idqr_pkg::DATA_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [DATA_WIDTH-1:0] r_i,
  input  logic [DATA_WIDTH-1:0] q_i,
  input  idqr_pkg::meta_t       meta_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output idqr_pkg::rsp_t        rsp_o
);

  logic                  valid_q;
  idqr_pkg::rsp_t        rsp_d, rsp_q;
  logic [DATA_WIDTH-1:0] x, y;

  always_comb begin
    x = meta_i.sel_rem ? r_i : q_i;
    y = meta_i.neg_res ? (~x + 1'b1) : x;
    rsp_d.result      = meta_i.dbz ? '0 : idqr_pkg::field_t'(y);
    rsp_d.div_by_zero = meta_i.dbz;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

>>> src/int64_divider_quotient_remainder.sv
`timescale 1ns / 1ps
// Pipeline: request to result passes through registered stages:
//   one operand-prep stage, one stage per restoring-division bit, one sign-fix stage.
// Throughput: one request per cycle; each stage holds one item and stalls only
//   when the stage after it is full and blocked, so bubbles are squeezed out.
// Reset: rst_ni is asynchronous, active low, and clears every stage's valid bit.
module int64_divider_quotient_remainder #(
  parameter int unsigned DATA_WIDTH = idqr_pkg::DATA_W
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  idqr_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output idqr_pkg::rsp_t rsp_o
);

  logic                  valid_s [0:DATA_WIDTH];
  logic                  ready_s [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] r_s     [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] nq_s    [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] den_s   [0:DATA_WIDTH];
  idqr_pkg::meta_t       meta_s  [0:DATA_WIDTH];

  idqr_prep #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_valid_i),
    .ready_o (req_ready_o),
    .req_i   (req_i),
    .valid_o (valid_s[0]),
    .ready_i (ready_s[0]),
    .r_o     (r_s[0]),
    .nq_o    (nq_s[0]),
    .den_o   (den_s[0]),
    .meta_o  (meta_s[0])
  );

  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
    idqr_step #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[k]),
      .ready_o (ready_s[k]),
      .r_i     (r_s[k]),
      .nq_i    (nq_s[k]),
      .den_i   (den_s[k]),
      .meta_i  (meta_s[k]),
      .valid_o (valid_s[k+1]),
      .ready_i (ready_s[k+1]),
      .r_o     (r_s[k+1]),
      .nq_o    (nq_s[k+1]),
      .den_o   (den_s[k+1]),
      .meta_o  (meta_s[k+1])
    );
  end

  idqr_post #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_s[DATA_WIDTH]),
    .ready_o (ready_s[DATA_WIDTH]),
    .r_i     (r_s[DATA_WIDTH]),
    .q_i     (nq_s[DATA_WIDTH]),
    .meta_i  (meta_s[DATA_WIDTH]),
    .valid_o (rsp_valid_o),
    .ready_i (rsp_ready_i),
    .rsp_o   (rsp_o)
  );

endmodule

>>> src/idqr_checker.sv
`timescale 1ns / 1ps

module idqr_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_ready_o,
  input idqr_pkg::req_t req_i,
  input logic           rsp_valid_o,
  input logic           rsp_ready_i,
  input idqr_pkg::rsp_t rsp_o
);

  // A zero-divisor request never reports a nonzero result.
  a_dbz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.div_by_zero |-> rsp_o.result == '0)
    else $error("div_by_zero with nonzero result");

  // With the consumer ready, every stage drains, so requests are taken.
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_ready_i |-> req_ready_o)
    else $error("request stalled while response side is ready");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !rsp_valid_o)
    else $error("response valid during reset");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("stalled response dropped or changed");

  // Hold a waiting request steady until it is taken.
  a_req_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && !req_ready_o |=> req_valid_i && $stable(req_i))
    else $error("waiting request dropped or changed");

endmodule

bind int64_divider_quotient_remainder idqr_checker u_idqr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_valid_i),
  .req_ready_o (req_ready_o),
  .req_i       (req_i),
  .rsp_valid_o (rsp_valid_o),
  .rsp_ready_i (rsp_ready_i),
  .rsp_o       (rsp_o)
);
